@@ hdl/tse_pkg.sv @@
package tse_pkg;

   localparam int RING_DEPTH   = 1024;
   localparam int MOTORS       = 4;
   localparam int LOOK_STEP    = 4;
   localparam int MAX_LOOKBACK = 64;

   localparam int DATA_W   = 32;
   localparam int HZ_W     = 27;
   localparam int MOTOR_W  = 2;
   localparam int IDX_W    = $clog2(RING_DEPTH);
   localparam int X_W      = $clog2(MAX_LOOKBACK + LOOK_STEP + 1);
   localparam int MEM_DEPTH = MOTORS * RING_DEPTH;
   localparam int ADDR_W   = $clog2(MEM_DEPTH);
   localparam int PROD_W   = DATA_W + HZ_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);
   localparam int PADDR_W  = 3;

   localparam logic [DATA_W-1:0] MIN_WINDOW_RESET = 32'd480000;
   localparam logic [HZ_W-1:0]   TIMER_HZ_RESET   = 27'd24000000;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic REG_MIN_WINDOW = 1'b0;
   localparam logic REG_TIMER_HZ   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD_RD,
      ST_HEAD_LATCH,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SIGN,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

@@ hdl/tse_req_if.sv @@
interface tse_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [tse_pkg::MOTOR_W-1:0]       motor;
   logic signed [tse_pkg::DATA_W-1:0] position;
   logic [tse_pkg::DATA_W-1:0]        timestamp;

   modport source (output valid, kind, motor, position, timestamp, input ready);
   modport sink (input valid, kind, motor, position, timestamp, output ready);
endinterface

@@ hdl/tse_rsp_if.sv @@
interface tse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tse_pkg::DATA_W-1:0] count;
   logic [tse_pkg::DATA_W-1:0]        count_time;
   logic signed [tse_pkg::DATA_W-1:0] speed;

   modport source (output valid, count, count_time, speed, input ready);
   modport sink (input valid, count, count_time, speed, output ready);
endinterface

@@ hdl/tacho_speed_estimator_core.sv @@
// Record request: taken back to back while idle; no response; passes a held response.
// Read request: head sample read, lookback walk (up to 16 steps), product, the shared
// bit-serial divider, then the output register; a still motor or a zero span skips to
// the output register. Not ready meanwhile.
// Reset (synchronous, active high) clears control state and the head/fill state per motor;
// ring entries never written since reset read as zero, so no clearing pass is needed.
module tacho_speed_estimator_core (
   input  logic                               clock,
   input  logic                               reset,
   tse_req_if.sink                            req_bus,
   tse_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tse_pkg::PADDR_W-1:0]        paddr,
   input  logic [tse_pkg::DATA_W-1:0]         pwdata,
   output logic [tse_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   localparam int DW = tse_pkg::DATA_W;
   localparam int IW = tse_pkg::IDX_W;

   // configuration
   logic [DW-1:0]            min_win_ff;
   logic [tse_pkg::HZ_W-1:0] hz_ff;
   logic                     csr_wr;
   logic                     csr_idx;

   // ring store and per-motor head / fill state
   logic [2*DW-1:0] ring_mem_ff [tse_pkg::MEM_DEPTH];
   logic [2*DW-1:0] rd_data_ff;
   logic            rd_valid_ff;
   logic            rd_valid_in;
   logic [IW-1:0]   head_ff [tse_pkg::MOTORS];
   logic            full_ff [tse_pkg::MOTORS];
   logic            mem_wr;
   logic [tse_pkg::ADDR_W-1:0] wr_addr;
   logic [tse_pkg::ADDR_W-1:0] rd_addr;
   logic [IW-1:0]   rd_slot;
   logic [IW-1:0]   rec_slot;

   // sequencer and datapath
   tse_pkg::state_type state_ff, state_in;
   logic [tse_pkg::MOTOR_W-1:0] m_ff, m_in;
   logic [tse_pkg::X_W-1:0]     x_ff, x_in;
   logic [DW-1:0]               hpos_ff, hpos_in;
   logic [DW-1:0]               htime_ff, htime_in;
   logic [DW-1:0]               dt_ff, dt_in;
   logic [DW-1:0]               dp_ff, dp_in;
   logic [DW-1:0]               mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic                        zero_ff, zero_in;
   logic [tse_pkg::PROD_W-1:0]  dvd_ff, dvd_in;
   logic [DW-1:0]               rem_ff, rem_in;
   logic [tse_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_count_ff, rsp_count_in;
   logic [DW-1:0] rsp_time_ff, rsp_time_in;
   logic [DW-1:0] rsp_speed_ff, rsp_speed_in;

   logic          req_take;
   logic          motor_ok;
   logic          out_free;
   logic [DW-1:0] tpos;
   logic [DW-1:0] ttime;
   logic [DW-1:0] dt_now;
   logic          pos_eq;
   logic          win_done;
   logic [DW:0]   rem_sh;
   logic          q_bit;
   logic [DW-1:0] quo;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[2];
   assign csr_wr  = psel & penable & pwrite;
   assign prdata  = (csr_idx == tse_pkg::REG_TIMER_HZ) ? DW'(hz_ff) : min_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_win_ff <= tse_pkg::MIN_WINDOW_RESET;
         hz_ff      <= tse_pkg::TIMER_HZ_RESET;
      end else if (csr_wr) begin
         if (csr_idx == tse_pkg::REG_MIN_WINDOW) begin
            min_win_ff <= pwdata;
         end else begin
            hz_ff <= pwdata[tse_pkg::HZ_W-1:0];
         end
      end
   end

   // ---------------- next state ----------------
   assign req_take = req_bus.valid & req_bus.ready;
   assign motor_ok = 32'(req_bus.motor) < tse_pkg::MOTORS;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign tpos     = rd_valid_ff ? rd_data_ff[2*DW-1:DW] : '0;
   assign ttime    = rd_valid_ff ? rd_data_ff[DW-1:0] : '0;
   assign dt_now   = htime_ff - ttime;
   assign pos_eq   = hpos_ff == tpos;
   assign win_done = (dt_now >= min_win_ff) || (32'(x_ff) >= tse_pkg::MAX_LOOKBACK);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tse_pkg::ST_IDLE: begin
            if (req_take && req_bus.kind == tse_pkg::KIND_READ) begin
               state_in = motor_ok ? tse_pkg::ST_HEAD_RD : tse_pkg::ST_FIN;
            end
         end
         tse_pkg::ST_HEAD_RD:    state_in = tse_pkg::ST_HEAD_LATCH;
         tse_pkg::ST_HEAD_LATCH: state_in = tse_pkg::ST_WALK_RD;
         tse_pkg::ST_WALK_RD:    state_in = tse_pkg::ST_WALK_CHK;
         tse_pkg::ST_WALK_CHK: begin
            if (pos_eq) begin
               state_in = tse_pkg::ST_FIN;
            end else if (win_done) begin
               state_in = tse_pkg::ST_SIGN;
            end else begin
               state_in = tse_pkg::ST_WALK_RD;
            end
         end
         tse_pkg::ST_SIGN: begin
            state_in = (dt_ff == '0) ? tse_pkg::ST_FIN : tse_pkg::ST_MUL;
         end
         tse_pkg::ST_MUL: state_in = tse_pkg::ST_DIV;
         tse_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = tse_pkg::ST_FIN;
            end
         end
         tse_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = tse_pkg::ST_IDLE;
            end
         end
         default: state_in = tse_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_bus.ready = 1'b0;
      mem_wr        = 1'b0;
      rd_slot       = head_ff[m_ff];
      case (state_ff)
         tse_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            mem_wr        = req_bus.valid && req_bus.kind == tse_pkg::KIND_RECORD && motor_ok;
         end
         tse_pkg::ST_WALK_RD: rd_slot = head_ff[m_ff] - IW'(x_ff);
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // ---------------- ring store ----------------
   assign rec_slot = head_ff[req_bus.motor] + IW'(1);
   assign wr_addr  = tse_pkg::ADDR_W'({req_bus.motor, rec_slot});
   assign rd_addr  = tse_pkg::ADDR_W'({m_ff, rd_slot});
   // slot 0 is the first to be written only after the ring wraps
   assign rd_valid_in = full_ff[m_ff] || (rd_slot != '0 && rd_slot <= head_ff[m_ff]);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         ring_mem_ff[wr_addr] <= {req_bus.position, req_bus.timestamp};
      end
      rd_data_ff  <= ring_mem_ff[rd_addr];
      rd_valid_ff <= rd_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tse_pkg::MOTORS; i++) begin
            head_ff[i] <= '0;
            full_ff[i] <= 1'b0;
         end
      end else if (mem_wr) begin
         head_ff[req_bus.motor] <= rec_slot;
         if (rec_slot == '0) begin
            full_ff[req_bus.motor] <= 1'b1;
         end
      end
   end

   // ---------------- datapath ----------------
   assign rem_sh = {rem_ff, dvd_ff[tse_pkg::PROD_W-1]};
   assign q_bit  = rem_sh >= {1'b0, dt_ff};
   assign quo    = dvd_ff[DW-1:0];

   always_comb begin
      m_in     = m_ff;
      x_in     = x_ff;
      hpos_in  = hpos_ff;
      htime_in = htime_ff;
      dt_in    = dt_ff;
      dp_in    = dp_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_speed_in = rsp_speed_ff;
      case (state_ff)
         tse_pkg::ST_IDLE: begin
            if (req_take) begin
               m_in     = req_bus.motor;
               zero_in  = !motor_ok;
               hpos_in  = '0;
               htime_in = '0;
            end
         end
         tse_pkg::ST_HEAD_LATCH: begin
            hpos_in  = tpos;
            htime_in = ttime;
            x_in     = tse_pkg::X_W'(tse_pkg::LOOK_STEP);
         end
         tse_pkg::ST_WALK_CHK: begin
            dt_in = dt_now;
            dp_in = hpos_ff - tpos;
            x_in  = x_ff + tse_pkg::X_W'(tse_pkg::LOOK_STEP);
            if (pos_eq) begin
               zero_in = 1'b1;
            end
         end
         tse_pkg::ST_SIGN: begin
            neg_in = dp_ff[DW-1];
            mag_in = dp_ff[DW-1] ? (DW'(0) - dp_ff) : dp_ff;
            if (dt_ff == '0) begin
               zero_in = 1'b1;
            end
         end
         tse_pkg::ST_MUL: begin
            dvd_in = tse_pkg::PROD_W'(mag_ff * hz_ff);
            rem_in = '0;
            cnt_in = tse_pkg::DIV_CNT_W'(tse_pkg::PROD_W - 1);
         end
         tse_pkg::ST_DIV: begin
            // restoring divide, one quotient bit per cycle shifted into the dividend
            rem_in = q_bit ? DW'(rem_sh - {1'b0, dt_ff}) : rem_sh[DW-1:0];
            dvd_in = {dvd_ff[tse_pkg::PROD_W-2:0], q_bit};
            cnt_in = cnt_ff - 1'b1;
         end
         tse_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = hpos_ff;
               rsp_time_in  = htime_ff;
               if (zero_ff) begin
                  rsp_speed_in = '0;
               end else begin
                  rsp_speed_in = neg_ff ? (DW'(0) - quo) : quo;
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      x_ff     <= x_in;
      hpos_ff  <= hpos_in;
      htime_ff <= htime_in;
      dt_ff    <= dt_in;
      dp_ff    <= dp_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.count      = rsp_count_ff;
   assign rsp_bus.count_time = rsp_time_ff;
   assign rsp_bus.speed      = rsp_speed_ff;

   // ---------------- assertions ----------------
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tse_pkg::ST_WALK_CHK
      |-> 32'(x_ff) < tse_pkg::MAX_LOOKBACK + tse_pkg::LOOK_STEP)
      else $error("lookback step past its bound");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == tse_pkg::ST_MUL
      |=> state_ff == tse_pkg::ST_DIV && 32'(cnt_ff) == tse_pkg::PROD_W - 1)
      else $error("divider not started with full count");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == tse_pkg::ST_DIV |-> dt_ff != '0)
      else $error("division by zero time span");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == tse_pkg::ST_FIN && rsp_valid_ff && !rsp_bus.ready
      |=> state_ff == tse_pkg::ST_FIN)
      else $error("response overwritten before taken");

   a_record_silent: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.kind == tse_pkg::KIND_RECORD && !rsp_valid_ff
      |=> !rsp_valid_ff)
      else $error("record request produced a response");

endmodule
